/* design/mpsra_pkg.sv */
package mpsra_pkg;

  localparam int PAGE_SLOTS = 8;
  localparam int PADDING    = 1;
  localparam int COORD_BITS = 13;

  localparam int PAD2      = 2 * PADDING;
  localparam int PAGE_MIN  = PAD2 + 1;
  localparam int PAGE_MAX  = 1 << (COORD_BITS - 1);
  localparam int IDX_W     = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int COUNT_W   = $clog2(PAGE_SLOTS + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int IN_W      = 64;
  localparam int OUT_W     = 88;

  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 2'd2;

  localparam logic [2:0] ST_PLACED   = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_TOO_BIG  = 3'd3;
  localparam logic [2:0] ST_CAPACITY = 3'd4;

  typedef struct packed {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] tallest;
  } page_rec_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            status;
    logic [COORD_BITS-1:0] aw;
    logic [COORD_BITS-1:0] ah;
  } chk_res_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] atlas_w;
    logic [COORD_BITS-1:0] atlas_h;
    logic [3:0]            page_limit;
  } cfg_t;

endpackage

/* design/multi_page_shelf_rect_allocator.sv */
// Shelf allocator for glyph rectangles over up to eight atlas pages. Each request is
// validated (zero size, stride, byte count, fit in the atlas), padded by one pixel
// on every side and placed first-fit on the open pages, wrapping to a new shelf when
// the row is full and opening a new page when none fits. One result per request, in
// order. The scan examines the open pages one page record per cycle, read from the
// page RAM; when none fits it falls through to opening a page or to reporting
// exhausted capacity, and a request rejected in the check skips the scan. Requests are
// handled one at a time; a new request is taken the cycle after the previous result
// has moved into the output register, so the input stalls while a result waits to
// enter it.
module multi_page_shelf_rect_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // glyph_width[12:0], glyph_height[25:13], stride[38:26], coverage_bytes[63:39]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], page[5:3], slot_x[17:6], slot_y[29:18], slot_width[42:30],
  // slot_height[55:43], ink_x[67:56], ink_y[79:68], open_pages[83:80], zero[87:84]
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import mpsra_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_NEW, S_OUT} state_t;

  state_t                state;
  cfg_t                  cfg;
  chk_res_t              chk;
  logic [IDX_W-1:0]      idx;
  logic [COUNT_W-1:0]    pages_open;
  logic [COORD_BITS-1:0] aw, ah;
  logic [2:0]            res_status;
  logic [IDX_W-1:0]      res_page;
  logic [COORD_BITS-1:0] res_x, res_y;
  logic                  res_placed;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  page_rec_t             ram_wdata, rec;

  logic                  accept;
  logic                  out_load;
  logic                  wrap, fit, more;
  logic [14:0]           end_x, py, bottom;
  logic [COORD_BITS-1:0] px, sh, nh;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state == S_IDLE;
  assign cfg_ready     = 1'b1;
  assign out_load      = state == S_OUT && (!m_axis_tvalid || m_axis_tready);

  mpsra_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  mpsra_check u_check (
    .clk            (clk),
    .rst            (rst),
    .start          (accept),
    .glyph_width    (s_axis_tdata[12:0]),
    .glyph_height   (s_axis_tdata[25:13]),
    .line_pitch     (s_axis_tdata[38:26]),
    .coverage_bytes (s_axis_tdata[63:39]),
    .cfg            (cfg),
    .res            (chk)
  );

  // one request in flight, write-back precedes the next read: no forwarding needed
  mpsra_page_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rec)
  );

  always_comb begin
    end_x  = 15'(rec.pos_x) + 15'(aw);
    wrap   = end_x > 15'(cfg.atlas_w);
    px     = wrap ? '0 : rec.pos_x;
    py     = wrap ? 15'(rec.pos_y) + 15'(rec.tallest) : 15'(rec.pos_y);
    sh     = wrap ? '0 : rec.tallest;
    bottom = py + 15'(ah);
    fit    = bottom <= 15'(cfg.atlas_h);
    nh     = (sh > ah) ? sh : ah;
    more   = (COUNT_W'(idx) + COUNT_W'(1)) < pages_open;

    ram_raddr = (state == S_SCAN) ? idx + IDX_W'(1) : '0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '{pos_x: COORD_BITS'(px + aw), pos_y: py[COORD_BITS-1:0], tallest: nh};
    if (state == S_SCAN && fit) begin
      ram_we = 1'b1;
    end else if (state == S_NEW && pages_open < COUNT_W'(cfg.page_limit)) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(pages_open);
      ram_wdata = '{pos_x: aw, pos_y: '0, tallest: ah};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pages_open    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (chk.valid) begin
            aw         <= chk.aw;
            ah         <= chk.ah;
            idx        <= '0;
            res_status <= chk.status;
            res_placed <= 1'b0;
            if (chk.status != ST_PLACED) begin
              state <= S_OUT;
            end else if (pages_open == '0) begin
              state <= S_NEW;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (fit) begin
            res_placed <= 1'b1;
            res_status <= ST_PLACED;
            res_page   <= idx;
            res_x      <= px;
            res_y      <= py[COORD_BITS-1:0];
            state      <= S_OUT;
          end else if (more) begin
            idx <= idx + IDX_W'(1);
          end else begin
            state <= S_NEW;
          end
        end
        S_NEW: begin
          if (pages_open < COUNT_W'(cfg.page_limit)) begin
            res_placed <= 1'b1;
            res_status <= ST_PLACED;
            res_page   <= IDX_W'(pages_open);
            res_x      <= '0;
            res_y      <= '0;
            pages_open <= pages_open + COUNT_W'(1);
          end else begin
            res_status <= ST_CAPACITY;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (out_load) begin
      m_axis_tdata[2:0]   <= res_status;
      m_axis_tdata[5:3]   <= res_placed ? 3'(res_page) : 3'd0;
      m_axis_tdata[17:6]  <= res_placed ? res_x[11:0] : 12'd0;
      m_axis_tdata[29:18] <= res_placed ? res_y[11:0] : 12'd0;
      m_axis_tdata[42:30] <= res_placed ? aw : 13'd0;
      m_axis_tdata[55:43] <= res_placed ? ah : 13'd0;
      m_axis_tdata[67:56] <= res_placed ? 12'(res_x + COORD_BITS'(PADDING)) : 12'd0;
      m_axis_tdata[79:68] <= res_placed ? 12'(res_y + COORD_BITS'(PADDING)) : 12'd0;
      m_axis_tdata[83:80] <= 4'(pages_open);
      m_axis_tdata[87:84] <= 4'd0;
    end
  end

`ifndef NO_ASSERTIONS
  a_pages_bounded: assert property (@(posedge clk) disable iff (rst)
    pages_open <= COUNT_W'(PAGE_SLOTS))
    else $error("open page count beyond page RAM depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> COUNT_W'(idx) < pages_open)
    else $error("page scan past last open page");

  a_pages_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (pages_open == $past(pages_open) ||
                     (pages_open == $past(pages_open) + COUNT_W'(1) && $past(state) == S_NEW)))
    else $error("open page count changed outside page opening");

  a_placed_has_page: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == ST_PLACED |-> m_axis_tdata[83:80] != 4'd0)
    else $error("placement reported with no open page");
`endif

endmodule

/* design/mpsra_page_ram.sv */
module mpsra_page_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [mpsra_pkg::IDX_W-1:0] waddr,
  input  mpsra_pkg::page_rec_t     wdata,
  input  logic [mpsra_pkg::IDX_W-1:0] raddr,
  output mpsra_pkg::page_rec_t     rdata
);
  import mpsra_pkg::*;

  page_rec_t mem [PAGE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mpsra_cfg_regs.sv */
module mpsra_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr,
  input  logic [mpsra_pkg::CFG_IDX_W-1:0] index,
  input  logic [mpsra_pkg::CFG_W-1:0]     data,
  output mpsra_pkg::cfg_t                 cfg
);
  import mpsra_pkg::*;

  logic [COORD_BITS-1:0] size_clamped;
  logic [3:0]            limit_clamped;

  always_comb begin
    if (int'(data) < PAGE_MIN) begin
      size_clamped = COORD_BITS'(PAGE_MIN);
    end else if (int'(data) > PAGE_MAX) begin
      size_clamped = COORD_BITS'(PAGE_MAX);
    end else begin
      size_clamped = COORD_BITS'(data);
    end
    if (data[3:0] == 4'd0) begin
      limit_clamped = 4'd1;
    end else if (int'(data[3:0]) > PAGE_SLOTS) begin
      limit_clamped = 4'(PAGE_SLOTS);
    end else begin
      limit_clamped = data[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.atlas_w    <= COORD_BITS'(1024);
      cfg.atlas_h    <= COORD_BITS'(1024);
      cfg.page_limit <= 4'(PAGE_SLOTS);
    end else if (wr) begin
      case (index)
        REG_ATLAS_W:    cfg.atlas_w    <= size_clamped;
        REG_ATLAS_H:    cfg.atlas_h    <= size_clamped;
        REG_PAGE_LIMIT: cfg.page_limit <= limit_clamped;
        default: ;
      endcase
    end
  end

endmodule

/* design/mpsra_check.sv */
module mpsra_check (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [12:0]           glyph_width,
  input  logic [12:0]           glyph_height,
  input  logic [12:0]           line_pitch,
  input  logic [24:0]           coverage_bytes,
  input  mpsra_pkg::cfg_t       cfg,
  output mpsra_pkg::chk_res_t   res
);
  import mpsra_pkg::*;

  logic        v1, v2;
  logic [12:0] w, h, stride;
  logic [24:0] bytes;
  logic [25:0] prod;
  logic [24:0] bytes2;
  logic        zero_dim, empty, stride_ok;
  logic [13:0] aw, ah;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
    if (start) begin
      w      <= glyph_width;
      h      <= glyph_height;
      stride <= line_pitch;
      bytes  <= coverage_bytes;
    end
    if (v1) begin
      prod      <= w * h;
      bytes2    <= bytes;
      zero_dim  <= (w == 13'd0) || (h == 13'd0);
      empty     <= (w == 13'd0) && (h == 13'd0) && (bytes == 25'd0);
      stride_ok <= stride == w;
      aw        <= {1'b0, w} + 14'(PAD2);
      ah        <= {1'b0, h} + 14'(PAD2);
    end
  end

  always_comb begin
    res.valid = v2;
    res.aw    = aw[COORD_BITS-1:0];
    res.ah    = ah[COORD_BITS-1:0];
    if (zero_dim) begin
      res.status = empty ? ST_EMPTY : ST_INVALID;
    end else if (!stride_ok || prod != {1'b0, bytes2}) begin
      res.status = ST_INVALID;
    end else if (aw > {1'b0, cfg.atlas_w} || ah > {1'b0, cfg.atlas_h}) begin
      res.status = ST_TOO_BIG;
    end else begin
      res.status = ST_PLACED;
    end
  end

endmodule
